// ===== rtl/rth_pkg.sv =====
package rth_pkg;

  localparam int COORD_BITS    = 20;
  localparam int FRAC_BITS     = 12;
  localparam int TOL_BITS      = 40;
  localparam int TAG_BITS      = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = (TOL_BITS > COORD_BITS) ? TOL_BITS : COORD_BITS;

  localparam logic [COORD_BITS-1:0] DIR_Z_RESET = COORD_BITS'(1 << FRAC_BITS);
  localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(34360);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_PAR_TOL
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic [TAG_BITS-1:0]          tri_tag;
  } rth_tri_t;

  typedef struct packed {
    logic                hit;
    logic [TAG_BITS-1:0] tag_out;
  } rth_res_t;

  // load enables of the three dot product stages
  typedef struct packed {
    logic pp;
    logic sum;
    logic fin;
  } rth_dot_en_t;

endpackage

// ===== rtl/rth_dot3.sv =====
module rth_dot3 #(
  parameter int AW = rth_pkg::COORD_BITS + 1,
  parameter int BW = 2 * rth_pkg::COORD_BITS + 3
) (
  input  logic                     clk,
  input  rth_pkg::rth_dot_en_t     en,
  input  logic signed [AW-1:0]     a [3],
  input  logic signed [BW-1:0]     b [3],
  output logic signed [AW+BW+1:0]  dot_r
);

  localparam int LW  = BW / 2;
  localparam int HW  = BW - LW;
  localparam int PLW = AW + LW + 1;
  localparam int PHW = AW + HW;
  localparam int SLW = PLW + 2;
  localparam int SHW = PHW + 2;
  localparam int RW  = AW + BW + 2;

  logic signed [PLW-1:0] pp_lo_r [3];
  logic signed [PHW-1:0] pp_hi_r [3];
  logic signed [PLW-1:0] pp_lo_nxt [3];
  logic signed [PHW-1:0] pp_hi_nxt [3];
  logic signed [SLW-1:0] sum_lo_r, sum_lo_nxt;
  logic signed [SHW-1:0] sum_hi_r, sum_hi_nxt;
  logic signed [RW-1:0]  dot_nxt;

  // wide factor split into an unsigned low half and a signed high half
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp_lo_nxt[i] = a[i] * $signed({1'b0, b[i][LW-1:0]});
      pp_hi_nxt[i] = a[i] * $signed(b[i][BW-1:LW]);
    end
    sum_lo_nxt = pp_lo_r[0] + pp_lo_r[1] + pp_lo_r[2];
    sum_hi_nxt = pp_hi_r[0] + pp_hi_r[1] + pp_hi_r[2];
    dot_nxt    = $signed({sum_hi_r, {LW{1'b0}}}) + sum_lo_r;
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (en.sum) begin
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
    if (en.fin) begin
      dot_r <= dot_nxt;
    end
  end

endmodule

// ===== rtl/ray_triangle_hit_test.sv =====
// Ray / triangle hit test, one fixed ray against a stream of triangles.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the ray origin, direction
// and parallel tolerance; write them only while no transaction is in flight.
// Input channel: in_valid/in_stall carry one triangle (three vertices, tag).
// Output channel: out_valid/out_stall carry the hit flag and the echoed tag.
// The datapath is a nine-stage pipeline: input register, differences, edge
// products, normal and ray cross product, three dot product stages (multipliers
// split into two partial products), flag stage and hit register. Exact math.
// Throughput: one triangle per cycle if out_stall is low; multipliers unshared.
// Stall: each stage holds when its successor is full and not moving; bubbles
// collapse, so input is taken while a result waits as long as a stage is free.
// in_stall rises only when all nine stages are occupied and out_stall is high.
// Reset: synchronous, clears all stage valid bits and loads the ray registers
// with origin 0, direction +z (1.0) and the default tolerance.
module ray_triangle_hit_test (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  rth_pkg::rth_tri_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rth_pkg::rth_res_t                      out_data,
  input  logic                                   cfg_we,
  input  logic [rth_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [rth_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  localparam int W    = rth_pkg::COORD_BITS;
  localparam int DFW  = W + 1;
  localparam int PW   = 2 * W + 2;
  localparam int CW   = 2 * W + 3;
  localparam int DW   = DFW + CW + 2;
  localparam int TW   = rth_pkg::TOL_BITS;
  localparam int CMPB = (DW > TW + 1) ? DW : TW + 1;
  localparam int CMPW = CMPB + 2;
  localparam int NS   = 9;

  typedef struct packed {
    logic pos;
    logic neg;
    logic u_neg;
    logic u_zero;
    logic vn_neg;
    logic vn_zero;
    logic t_neg;
    logic t_zero;
    logic d_neg;
    logic d_zero;
  } flags_t;

  // ray registers
  logic signed [W-1:0]  org_r [3];
  logic signed [W-1:0]  dir_r [3];
  logic [TW-1:0]        tol_r;

  // pipeline control
  logic [NS-1:0]        v_r, v_nxt;
  logic [NS:0]          rdy;
  logic [rth_pkg::TAG_BITS-1:0] tag_r [NS];

  // stage payloads
  logic signed [W-1:0]   va_r [3], vb_r [3], vc_r [3];
  logic signed [DFW-1:0] q1_r [3], e11_r [3], e21_r [3];
  logic signed [DFW-1:0] q1_nxt [3], e11_nxt [3], e21_nxt [3];
  logic signed [DFW-1:0] q2_r [3], e12_r [3], e22_r [3];
  logic signed [DFW-1:0] q3_r [3], e13_r [3], e23_r [3];
  logic signed [DFW-1:0] dir_ext [3];
  logic signed [PW-1:0]  prod_r [12], prod_nxt [12];
  logic signed [CW-1:0]  nrm_r [3], nrm_nxt [3];
  logic signed [CW-1:0]  rxq_r [3], rxq_nxt [3];
  logic signed [DW-1:0]  dn_dot, t_dot, u_dot, vn_dot;
  rth_pkg::rth_dot_en_t  dot_en;

  flags_t                flg_r, flg_nxt;
  logic                  hit_r, hit_nxt;

  logic signed [CMPW-1:0] dn_x, u_x, vn_x, tol_x, dn_plus, diff;

  // ready ripples back from the output; an empty stage is always ready
  always_comb begin
    rdy[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      v_nxt[k] = v_r[k-1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_data  = '{hit: hit_r, tag_out: tag_r[NS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= $signed(rth_pkg::DIR_Z_RESET);
      tol_r    <= rth_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (rth_pkg::cfg_reg_t'(cfg_addr))
        rth_pkg::REG_ORIGIN_X: org_r[0] <= $signed(cfg_wdata[W-1:0]);
        rth_pkg::REG_ORIGIN_Y: org_r[1] <= $signed(cfg_wdata[W-1:0]);
        rth_pkg::REG_ORIGIN_Z: org_r[2] <= $signed(cfg_wdata[W-1:0]);
        rth_pkg::REG_DIR_X:    dir_r[0] <= $signed(cfg_wdata[W-1:0]);
        rth_pkg::REG_DIR_Y:    dir_r[1] <= $signed(cfg_wdata[W-1:0]);
        rth_pkg::REG_DIR_Z:    dir_r[2] <= $signed(cfg_wdata[W-1:0]);
        rth_pkg::REG_PAR_TOL:  tol_r    <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_ext[i] = DFW'(dir_r[i]);
      q1_nxt[i]  = org_r[i] - va_r[i];
      e11_nxt[i] = vb_r[i] - va_r[i];
      e21_nxt[i] = vc_r[i] - va_r[i];
    end
    // normal terms, then dir x q terms
    prod_nxt[0]  = e11_r[1] * e21_r[2];
    prod_nxt[1]  = e11_r[2] * e21_r[1];
    prod_nxt[2]  = e11_r[2] * e21_r[0];
    prod_nxt[3]  = e11_r[0] * e21_r[2];
    prod_nxt[4]  = e11_r[0] * e21_r[1];
    prod_nxt[5]  = e11_r[1] * e21_r[0];
    prod_nxt[6]  = dir_ext[1] * q1_r[2];
    prod_nxt[7]  = dir_ext[2] * q1_r[1];
    prod_nxt[8]  = dir_ext[2] * q1_r[0];
    prod_nxt[9]  = dir_ext[0] * q1_r[2];
    prod_nxt[10] = dir_ext[0] * q1_r[1];
    prod_nxt[11] = dir_ext[1] * q1_r[0];
    for (int i = 0; i < 3; i++) begin
      nrm_nxt[i] = prod_r[2*i] - prod_r[2*i+1];
      rxq_nxt[i] = prod_r[6+2*i] - prod_r[7+2*i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      va_r     <= '{$signed(in_data.a_x), $signed(in_data.a_y), $signed(in_data.a_z)};
      vb_r     <= '{$signed(in_data.b_x), $signed(in_data.b_y), $signed(in_data.b_z)};
      vc_r     <= '{$signed(in_data.c_x), $signed(in_data.c_y), $signed(in_data.c_z)};
      tag_r[0] <= in_data.tri_tag;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
    if (rdy[1]) begin
      q1_r  <= q1_nxt;
      e11_r <= e11_nxt;
      e21_r <= e21_nxt;
    end
    if (rdy[2]) begin
      prod_r <= prod_nxt;
      q2_r   <= q1_r;
      e12_r  <= e11_r;
      e22_r  <= e21_r;
    end
    if (rdy[3]) begin
      nrm_r <= nrm_nxt;
      rxq_r <= rxq_nxt;
      q3_r  <= q2_r;
      e13_r <= e12_r;
      e23_r <= e22_r;
    end
    if (rdy[7]) begin
      flg_r <= flg_nxt;
    end
    if (rdy[8]) begin
      hit_r <= hit_nxt;
    end
  end

  assign dot_en = '{pp: rdy[4], sum: rdy[5], fin: rdy[6]};

  // dn = dir.n, t_dot = q.n, u = e2.(dir x q), vn = e1.(dir x q) = -v
  rth_dot3 #(.AW(DFW), .BW(CW)) u_dot_dn (
    .clk(clk), .en(dot_en), .a(dir_ext), .b(nrm_r), .dot_r(dn_dot)
  );
  rth_dot3 #(.AW(DFW), .BW(CW)) u_dot_t (
    .clk(clk), .en(dot_en), .a(q3_r), .b(nrm_r), .dot_r(t_dot)
  );
  rth_dot3 #(.AW(DFW), .BW(CW)) u_dot_u (
    .clk(clk), .en(dot_en), .a(e23_r), .b(rxq_r), .dot_r(u_dot)
  );
  rth_dot3 #(.AW(DFW), .BW(CW)) u_dot_vn (
    .clk(clk), .en(dot_en), .a(e13_r), .b(rxq_r), .dot_r(vn_dot)
  );

  always_comb begin
    dn_x    = CMPW'(dn_dot);
    u_x     = CMPW'(u_dot);
    vn_x    = CMPW'(vn_dot);
    tol_x   = $signed({{(CMPW-TW){1'b0}}, tol_r});
    dn_plus = dn_x + tol_x;
    diff    = dn_x - u_x + vn_x;
    flg_nxt.pos     = dn_x > tol_x;
    flg_nxt.neg     = dn_plus[CMPW-1];
    flg_nxt.u_neg   = u_dot[DW-1];
    flg_nxt.u_zero  = (u_dot == '0);
    flg_nxt.vn_neg  = vn_dot[DW-1];
    flg_nxt.vn_zero = (vn_dot == '0);
    flg_nxt.t_neg   = t_dot[DW-1];
    flg_nxt.t_zero  = (t_dot == '0);
    flg_nxt.d_neg   = diff[CMPW-1];
    flg_nxt.d_zero  = (diff == '0);
    // front facing: v = -vn; back facing: all tests mirror
    hit_nxt = (flg_r.pos && !flg_r.u_neg && (flg_r.vn_neg || flg_r.vn_zero)
               && !flg_r.d_neg && (flg_r.t_neg || flg_r.t_zero))
           || (flg_r.neg && (flg_r.u_neg || flg_r.u_zero) && !flg_r.vn_neg
               && (flg_r.d_neg || flg_r.d_zero) && !flg_r.t_neg);
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with a free pipeline stage");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is moving");

  a_facing_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] |-> !(flg_r.pos && flg_r.neg))
    else $error("front and back facing both set");

  a_hold_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && out_stall) |=> (v_r[NS-1] && $stable(tag_r[NS-1]) && $stable(hit_r)))
    else $error("stalled result lost or changed");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = rth_pkg::COORD_BITS;
  localparam int TOL_W   = rth_pkg::TOL_BITS;
  localparam int TAG_W   = rth_pkg::TAG_BITS;
  localparam int ADDR_W  = rth_pkg::CFG_ADDR_BITS;
  localparam int DATA_W  = rth_pkg::CFG_DATA_BITS;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    wide_t x;
    wide_t y;
    wide_t z;
  } wvec_t;

  localparam int ONE   = 1 << rth_pkg::FRAC_BITS;
  localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int C_MIN = -(1 << (COORD_W - 1));
  // index past the last ray register
  localparam logic [ADDR_W-1:0] REG_UNUSED = '1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  rth_pkg::rth_tri_t    in_data;
  logic                 out_valid;
  logic                 out_stall;
  rth_pkg::rth_res_t    out_data;
  logic                 cfg_we;
  logic [ADDR_W-1:0]    cfg_addr;
  logic [DATA_W-1:0]    cfg_wdata;

  // shadow copy of the ray registers
  logic signed [COORD_W-1:0] ray_org [3];
  logic signed [COORD_W-1:0] ray_dir [3];
  logic [TOL_W-1:0]          ray_tol;

  rth_pkg::rth_res_t pending_hits [$];
  int       error_count = 0;
  int       hold_left = 0;
  bit       quiet = 1'b0;

  ray_triangle_hit_test i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wvec_t to_wvec(input logic signed [COORD_W-1:0] x, y, z);
    wvec_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic wvec_t wsub(input wvec_t a, b);
    wvec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wvec_t wcross(input wvec_t a, b);
    wvec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t wdot(input wvec_t a, b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic logic predict_hit(input rth_pkg::rth_tri_t tri_in);
    wvec_t org, dir, va, vb, vc, q, e1, e2, nrm;
    wide_t tol_w, dn, u, v, t;
    logic  flip;
    org = to_wvec(ray_org[0], ray_org[1], ray_org[2]);
    dir = to_wvec(ray_dir[0], ray_dir[1], ray_dir[2]);
    va  = to_wvec($signed(tri_in.a_x), $signed(tri_in.a_y), $signed(tri_in.a_z));
    vb  = to_wvec($signed(tri_in.b_x), $signed(tri_in.b_y), $signed(tri_in.b_z));
    vc  = to_wvec($signed(tri_in.c_x), $signed(tri_in.c_y), $signed(tri_in.c_z));
    q   = wsub(org, va);
    e1  = wsub(vb, va);
    e2  = wsub(vc, va);
    nrm = wcross(e1, e2);
    tol_w = '0;
    tol_w[TOL_W-1:0] = ray_tol;
    dn = wdot(dir, nrm);
    if (dn > tol_w) begin
      flip = 1'b0;
    end else if (dn < -tol_w) begin
      flip = 1'b1;
      dn   = -dn;
    end else begin
      // parallel, degenerate or zero direction
      return 1'b0;
    end
    u = wdot(dir, wcross(q, e2));
    v = wdot(dir, wcross(e1, q));
    t = wdot(q, nrm);
    if (flip) begin
      u = -u;
      v = -v;
    end else begin
      t = -t;
    end
    return (u >= 0) && (v >= 0) && (u + v <= dn) && (t >= 0);
  endfunction

  function automatic rth_pkg::rth_tri_t make_tri(input int ax, ay, az, bx, by, bz,
                                                 cx, cy, cz, tag);
    rth_pkg::rth_tri_t r;
    r.a_x = COORD_W'(ax);
    r.a_y = COORD_W'(ay);
    r.a_z = COORD_W'(az);
    r.b_x = COORD_W'(bx);
    r.b_y = COORD_W'(by);
    r.b_z = COORD_W'(bz);
    r.c_x = COORD_W'(cx);
    r.c_y = COORD_W'(cy);
    r.c_z = COORD_W'(cz);
    r.tri_tag = TAG_W'(tag);
    return r;
  endfunction

  function automatic int rand_offset(input int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // triangle around a point on the ray line, a little before or past the origin
  function automatic rth_pkg::rth_tri_t near_ray_tri(input int spread);
    int s, px, py, pz;
    int vx [3];
    int vy [3];
    int vz [3];
    s  = int'($urandom_range(0, 16)) - 4;
    px = ray_org[0] + (ray_dir[0] * s) / 4;
    py = ray_org[1] + (ray_dir[1] * s) / 4;
    pz = ray_org[2] + (ray_dir[2] * s) / 4;
    for (int i = 0; i < 3; i++) begin
      vx[i] = px + rand_offset(spread);
      vy[i] = py + rand_offset(spread);
      vz[i] = pz + rand_offset(spread);
    end
    if ($urandom_range(0, 19) == 0) begin
      vx[2] = vx[0];
      vy[2] = vy[0];
      vz[2] = vz[0];
    end
    return make_tri(vx[0], vy[0], vz[0], vx[1], vy[1], vz[1],
                    vx[2], vy[2], vz[2], $urandom);
  endfunction

  function automatic rth_pkg::rth_tri_t pick_tri();
    int r;
    int spread;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return make_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: spread = $urandom_range(16, 4096);
      5, 6, 7:       spread = $urandom_range(4096, 65536);
      8:             spread = 262144;
      default:       spread = C_MAX;
    endcase
    return near_ray_tri(spread);
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // coordinate in the low bits, junk above that the block must drop
  function automatic logic [DATA_W-1:0] coord_word(input int v);
    logic [DATA_W-1:0] w;
    w = DATA_W'({$urandom, $urandom});
    w[COORD_W-1:0] = COORD_W'(v);
    return w;
  endfunction

  task automatic send_triangle(input rth_pkg::rth_tri_t tri_item);
    rth_pkg::rth_res_t r;
    repeat (gap_len()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= tri_item;
    do @(posedge clk); while (in_stall);
    r.hit     = predict_hit(tri_item);
    r.tag_out = tri_item.tri_tag;
    pending_hits.push_back(r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      rth_pkg::REG_ORIGIN_X: ray_org[0] = data[COORD_W-1:0];
      rth_pkg::REG_ORIGIN_Y: ray_org[1] = data[COORD_W-1:0];
      rth_pkg::REG_ORIGIN_Z: ray_org[2] = data[COORD_W-1:0];
      rth_pkg::REG_DIR_X:    ray_dir[0] = data[COORD_W-1:0];
      rth_pkg::REG_DIR_Y:    ray_dir[1] = data[COORD_W-1:0];
      rth_pkg::REG_DIR_Z:    ray_dir[2] = data[COORD_W-1:0];
      rth_pkg::REG_PAR_TOL:  ray_tol    = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_ray(input int ox, oy, oz, dx, dy, dz,
                             input logic [TOL_W-1:0] tol);
    drain_results();
    write_reg(rth_pkg::REG_ORIGIN_X, coord_word(ox));
    write_reg(rth_pkg::REG_ORIGIN_Y, coord_word(oy));
    write_reg(rth_pkg::REG_ORIGIN_Z, coord_word(oz));
    write_reg(rth_pkg::REG_DIR_X, coord_word(dx));
    write_reg(rth_pkg::REG_DIR_Y, coord_word(dy));
    write_reg(rth_pkg::REG_DIR_Z, coord_word(dz));
    write_reg(rth_pkg::REG_PAR_TOL, DATA_W'(tol));
  endtask

  // ray after reset: origin 0, direction +z
  task automatic test_default_ray();
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 0));
    send_triangle(make_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE, 'hFFFF));
    // reversed winding flips the sign of dir.n
    send_triangle(make_tri(-ONE, -ONE, ONE, 0, ONE, ONE, ONE, -ONE, ONE, 1));
    // ray through a vertex and through an edge
    send_triangle(make_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE, 2));
    send_triangle(make_tri(-ONE, 0, ONE, ONE, 0, ONE, 0, ONE, ONE, 3));
    // triangle through the origin, distance zero
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 4));
    send_triangle(make_tri(ONE, -ONE, ONE, 3 * ONE, -ONE, ONE, 2 * ONE, ONE, ONE, 5));
  endtask

  task automatic test_degenerate();
    send_triangle(make_tri(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, ONE, 6));
    send_triangle(make_tri(-ONE, -ONE, ONE, -ONE, -ONE, ONE, 0, ONE, ONE, 7));
    // plane holds the ray
    send_triangle(make_tri(0, -ONE, 0, 0, ONE, 0, 0, 0, ONE, 8));
  endtask

  task automatic test_extremes();
    send_triangle(make_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                           C_MAX, C_MAX, C_MAX, 'hFFFF));
    send_triangle(make_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                           C_MIN, C_MIN, C_MIN, 0));
    send_triangle(make_tri(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                           0, C_MAX, C_MAX, 'hAAAA));
    send_triangle(make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN,
                           0, C_MAX, C_MIN, 'h5555));
    send_triangle(make_tri(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                           C_MAX, C_MIN, C_MAX, 'h8001));
  endtask

  task automatic test_tolerance();
    logic [TOL_W-1:0] knee_tol;
    // dir.n of the unit test triangle below is exactly 2^38
    knee_tol = '0;
    knee_tol[38] = 1'b1;
    program_ray(0, 0, 0, 0, 0, ONE, knee_tol);
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 9));
    program_ray(0, 0, 0, 0, 0, ONE, knee_tol - 1);
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 10));
    program_ray(0, 0, 0, 0, 0, ONE, '1);
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 11));
    program_ray(0, 0, 0, 0, 0, ONE, '0);
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 12));
  endtask

  task automatic test_zero_dir();
    program_ray(0, 0, 0, 0, 0, 0, '0);
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 13));
    send_triangle(make_tri(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                           0, C_MAX, C_MAX, 14));
  endtask

  task automatic test_unused_index();
    program_ray(0, 0, 0, 0, 0, ONE, '0);
    write_reg(REG_UNUSED, '1);
    send_triangle(make_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 15));
    send_triangle(make_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE, 16));
  endtask

  task automatic test_random_rays();
    int ox, oy, oz, dx, dy, dz, o_span, d_span;
    logic [TOL_W-1:0] tol;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: program_ray(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, '0);
        1: program_ray(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, rth_pkg::TOL_RESET);
        default: begin
          o_span = ($urandom_range(0, 3) == 0) ? C_MAX : 65536;
          d_span = ($urandom_range(0, 3) == 0) ? C_MAX : 8192;
          ox = rand_offset(o_span);
          oy = rand_offset(o_span);
          oz = rand_offset(o_span);
          dx = rand_offset(d_span);
          dy = rand_offset(d_span);
          dz = rand_offset(d_span);
          case ($urandom_range(0, 3))
            0:       tol = '0;
            1:       tol = rth_pkg::TOL_RESET;
            2:       tol = TOL_W'($urandom_range(0, 1 << 20));
            default: tol = TOL_W'({$urandom, $urandom});
          endcase
          program_ray(ox, oy, oz, dx, dy, dz, tol);
        end
      endcase
      repeat (60) send_triangle(pick_tri());
    end
  endtask

  // result side held off while triangles keep coming, so the pipe fills up
  task automatic test_back_pressure();
    program_ray(rand_offset(4096), rand_offset(4096), rand_offset(4096),
                rand_offset(8192), rand_offset(8192), ONE, rth_pkg::TOL_RESET);
    hold_left = 80;
    quiet = 1'b1;
    repeat (40) send_triangle(pick_tri());
    quiet = 1'b0;
    drain_results();
    repeat (20) send_triangle(pick_tri());
  endtask

  task automatic test_no_idle();
    drain_results();
    quiet = 1'b1;
    repeat (100) send_triangle(pick_tri());
    quiet = 1'b0;
  endtask

  // result side stall pattern
  initial begin
    int  run_len;
    int  r;
    logic level;
    out_stall = 1'b0;
    run_len = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        run_len = 0;
        out_stall <= 1'b0;
      end else begin
        if (run_len == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            level = 1'b0;
            run_len = $urandom_range(1, 12);
          end else if (r < 85) begin
            level = 1'b1;
            run_len = $urandom_range(1, 3);
          end else if (r < 97) begin
            level = 1'b1;
            run_len = $urandom_range(4, 10);
          end else begin
            level = 1'b1;
            run_len = $urandom_range(20, 40);
          end
        end
        run_len--;
        out_stall <= level;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rth_pkg::rth_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result transaction with nothing pending, tag_out %h", out_data.tag_out);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %b, actual %b", want.hit, out_data.hit);
          error_count++;
        end
        if (out_data.tag_out !== want.tag_out) begin
          $error("tag_out: expected %h, actual %h", want.tag_out, out_data.tag_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    ray_org   = '{0, 0, 0};
    ray_dir   = '{0, 0, rth_pkg::DIR_Z_RESET};
    ray_tol   = rth_pkg::TOL_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_default_ray();
    test_degenerate();
    test_extremes();
    test_tolerance();
    test_zero_dir();
    test_unused_index();
    test_random_rays();
    test_back_pressure();
    test_no_idle();

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
